### rtl/tomx_pkg.sv
// Package: shared widths, constants, register indexes and the type tag for the extractor.
`default_nettype none
package tomx_pkg;

	localparam int TAG_LENGTH_DEF    = 11;
	localparam int MAX_WORDS_DEF     = 16;
	localparam int POSITION_BITS_DEF = 11;
	localparam int TAG_CAP           = 16;

	localparam int START_W  = 11;
	localparam int GAP_W    = 6;
	localparam int TOTAL_W  = 5;
	localparam int BYTE_W   = 8;
	localparam int WORD_W   = 32;
	localparam int INDEX_W  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [START_W-1:0] FIRST_START_RST = 11'd20;
	localparam logic [START_W-1:0] LAST_START_RST  = 11'd99;
	localparam logic [GAP_W-1:0]   GAP_BYTES_RST   = 6'd8;
	localparam logic [TOTAL_W-1:0] WORD_TOTAL_RST  = 5'd10;

	// "siiffffffff", zero padded
	localparam logic [BYTE_W-1:0] TAG_CHARS [TAG_CAP] = '{
		8'h73, 8'h69, 8'h69, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66,
		8'h66, 8'h66, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_START = 2'd0,
		REG_LAST_START  = 2'd1,
		REG_GAP_BYTES   = 2'd2,
		REG_WORD_TOTAL  = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		PH_SEARCH  = 4'b0001,
		PH_SKIP    = 4'b0010,
		PH_COLLECT = 4'b0100,
		PH_DONE    = 4'b1000
	} phase_t;

endpackage
`default_nettype wire

### rtl/tomx_in_if.sv
// Interface: packet byte request channel.
`default_nettype none
interface tomx_in_if;
	logic                          valid;
	logic                          ready;
	logic [tomx_pkg::BYTE_W-1:0]   data_byte;
	logic                          end_of_packet;

	modport source (output valid, output data_byte, output end_of_packet, input ready);
	modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface
`default_nettype wire

### rtl/tomx_out_if.sv
// Interface: attribute word result channel.
`default_nettype none
interface tomx_out_if;
	logic                          valid;
	logic                          ready;
	logic [tomx_pkg::WORD_W-1:0]   attribute_word;
	logic [tomx_pkg::INDEX_W-1:0]  word_index;
	logic                          last_word;

	modport source (output valid, output attribute_word, output word_index,
		output last_word, input ready);
	modport sink   (input valid, input attribute_word, input word_index,
		input last_word, output ready);
endinterface
`default_nettype wire

### rtl/tomx_cfg_if.sv
// Interface: configuration register write channel.
`default_nettype none
interface tomx_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tomx_pkg::CFG_IDX_W-1:0]    index;
	logic [tomx_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/tuio_object_message_extractor_core.sv
// Top level: tag search, gap skip and big-endian attribute word packing.
//
// channel   dir  payload                                   request when
// pkt_in    in   data_byte[7:0], end_of_packet             valid && ready
// attr_out  out  attribute_word[31:0], word_index[3:0],    valid && ready
//                last_word
// cfg       in   index[1:0], data[10:0]                    valid && ready
//
// One byte per cycle; the byte is processed in its accept cycle and a word,
// if any, lands in the output register for the next cycle.
// pkt_in.ready drops only while the output register holds a word not taken.
// cfg.ready is always high; writes take effect at the next byte.
// arst_n clears state and loads the default register values.
`default_nettype none
module tuio_object_message_extractor_core #(
	parameter int TAG_LENGTH    = tomx_pkg::TAG_LENGTH_DEF,
	parameter int MAX_WORDS     = tomx_pkg::MAX_WORDS_DEF,
	parameter int POSITION_BITS = tomx_pkg::POSITION_BITS_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	tomx_in_if.sink        pkt_in,
	tomx_out_if.source     attr_out,
	tomx_cfg_if.sink       cfg
);

	localparam int CMP_W = (POSITION_BITS > tomx_pkg::START_W) ? POSITION_BITS
		: tomx_pkg::START_W;

	logic [tomx_pkg::START_W-1:0] first_start_q, last_start_q;
	logic [tomx_pkg::GAP_W-1:0]   gap_bytes_q;
	logic [tomx_pkg::TOTAL_W-1:0] word_total_q;

	logic [POSITION_BITS-1:0]     pos_q, pos_d;
	logic [tomx_pkg::BYTE_W-1:0]  recent_q [TAG_LENGTH];
	logic [tomx_pkg::BYTE_W-1:0]  recent_d [TAG_LENGTH];
	tomx_pkg::phase_t             phase_q, phase_d;
	logic [tomx_pkg::GAP_W-1:0]   skip_q, skip_d;
	logic [23:0]                  builder_q, builder_d;
	logic [1:0]                   biw_q, biw_d;
	logic [tomx_pkg::INDEX_W-1:0] wcnt_q, wcnt_d;

	logic                         out_valid_q;
	logic [tomx_pkg::WORD_W-1:0]  out_word_q;
	logic [tomx_pkg::INDEX_W-1:0] out_index_q;
	logic                         out_last_q;

	logic                         acc;
	logic                         emit, emit_last;
	logic [tomx_pkg::TOTAL_W-1:0] eff_total;
	logic [POSITION_BITS-1:0]     start;
	logic                         in_window, tag_hit;
	logic [tomx_pkg::GAP_W-1:0]   skip_inc;

	assign pkt_in.ready = !out_valid_q || attr_out.ready;
	assign acc          = pkt_in.valid && pkt_in.ready;
	assign cfg.ready    = 1'b1;

	assign attr_out.valid          = out_valid_q;
	assign attr_out.attribute_word = out_word_q;
	assign attr_out.word_index     = out_index_q;
	assign attr_out.last_word      = out_last_q;

	assign eff_total = (word_total_q > tomx_pkg::TOTAL_W'(MAX_WORDS))
		? tomx_pkg::TOTAL_W'(MAX_WORDS) : word_total_q;
	assign start     = pos_q - POSITION_BITS'(TAG_LENGTH - 1);
	assign in_window = (CMP_W'(start) >= CMP_W'(first_start_q))
		&& (CMP_W'(start) <= CMP_W'(last_start_q));
	assign skip_inc  = skip_q + tomx_pkg::GAP_W'(1);
	assign emit_last = ({1'b0, wcnt_q} + tomx_pkg::TOTAL_W'(1)) >= eff_total;

	always_comb begin
		// shift line: oldest byte at index 0
		for (int i = 0; i < TAG_LENGTH - 1; i++) begin
			recent_d[i] = recent_q[i+1];
		end
		recent_d[TAG_LENGTH-1] = pkt_in.data_byte;

		tag_hit = (pos_q >= POSITION_BITS'(TAG_LENGTH - 1)) && in_window;
		for (int i = 0; i < TAG_LENGTH; i++) begin
			if (recent_d[i] != tomx_pkg::TAG_CHARS[i]) tag_hit = 1'b0;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		skip_d    = skip_q;
		builder_d = builder_q;
		biw_d     = biw_q;
		wcnt_d    = wcnt_q;
		emit      = 1'b0;
		pos_d     = (pos_q != {POSITION_BITS{1'b1}}) ? pos_q + POSITION_BITS'(1) : pos_q;

		case (phase_q)
			tomx_pkg::PH_SEARCH: begin
				if (tag_hit) begin
					skip_d    = '0;
					biw_d     = '0;
					builder_d = '0;
					wcnt_d    = '0;
					if (eff_total == '0) phase_d = tomx_pkg::PH_DONE;
					else if (gap_bytes_q == '0) phase_d = tomx_pkg::PH_COLLECT;
					else phase_d = tomx_pkg::PH_SKIP;
				end
			end
			tomx_pkg::PH_SKIP: begin
				skip_d = skip_inc;
				// a wrapped counter also ends the gap
				if (skip_inc >= gap_bytes_q || skip_inc == '0) phase_d = tomx_pkg::PH_COLLECT;
			end
			tomx_pkg::PH_COLLECT: begin
				if (biw_q == 2'd3) begin
					emit      = 1'b1;
					builder_d = '0;
					biw_d     = '0;
					wcnt_d    = wcnt_q + tomx_pkg::INDEX_W'(1);
					if (emit_last) phase_d = tomx_pkg::PH_DONE;
				end else begin
					builder_d = {builder_q[15:0], pkt_in.data_byte};
					biw_d     = biw_q + 2'd1;
				end
			end
			tomx_pkg::PH_DONE: begin
			end
			default: begin
				phase_d = tomx_pkg::PH_SEARCH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_start_q <= tomx_pkg::FIRST_START_RST;
			last_start_q  <= tomx_pkg::LAST_START_RST;
			gap_bytes_q   <= tomx_pkg::GAP_BYTES_RST;
			word_total_q  <= tomx_pkg::WORD_TOTAL_RST;
		end else if (cfg.valid) begin
			case (tomx_pkg::cfg_reg_t'(cfg.index))
				tomx_pkg::REG_FIRST_START: first_start_q <= cfg.data[tomx_pkg::START_W-1:0];
				tomx_pkg::REG_LAST_START:  last_start_q  <= cfg.data[tomx_pkg::START_W-1:0];
				tomx_pkg::REG_GAP_BYTES:   gap_bytes_q   <= cfg.data[tomx_pkg::GAP_W-1:0];
				tomx_pkg::REG_WORD_TOTAL:  word_total_q  <= cfg.data[tomx_pkg::TOTAL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			phase_q   <= tomx_pkg::PH_SEARCH;
			skip_q    <= '0;
			builder_q <= '0;
			biw_q     <= '0;
			wcnt_q    <= '0;
			for (int i = 0; i < TAG_LENGTH; i++) recent_q[i] <= '0;
		end else if (acc) begin
			if (pkt_in.end_of_packet) begin
				pos_q     <= '0;
				phase_q   <= tomx_pkg::PH_SEARCH;
				skip_q    <= '0;
				builder_q <= '0;
				biw_q     <= '0;
				wcnt_q    <= '0;
				for (int i = 0; i < TAG_LENGTH; i++) recent_q[i] <= '0;
			end else begin
				pos_q     <= pos_d;
				phase_q   <= phase_d;
				skip_q    <= skip_d;
				builder_q <= builder_d;
				biw_q     <= biw_d;
				wcnt_q    <= wcnt_d;
				for (int i = 0; i < TAG_LENGTH; i++) recent_q[i] <= recent_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pkt_in.ready) begin
			out_valid_q <= acc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && emit) begin
			out_word_q  <= {builder_q, pkt_in.data_byte};
			out_index_q <= wcnt_q;
			out_last_q  <= emit_last;
		end
	end

	a_eop_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		acc && pkt_in.end_of_packet |=> pos_q == '0)
		else $error("position not cleared after end of packet");

	a_search_idle: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == tomx_pkg::PH_SEARCH |-> wcnt_q == '0 && biw_q == '0 && skip_q == '0)
		else $error("word state busy while searching");

	a_last_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		acc && emit && emit_last && !pkt_in.end_of_packet |=> phase_q == tomx_pkg::PH_DONE)
		else $error("final word did not end collection");

	a_pos_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !pkt_in.end_of_packet |=> pos_q >= $past(pos_q))
		else $error("position went backward within a packet");

	a_skip_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == tomx_pkg::PH_SKIP |-> biw_q == '0 && wcnt_q == '0)
		else $error("bytes packed during gap");

endmodule
`default_nettype wire

### dv/tb_tuio_object_message_extractor_core.sv
// Testbench: random and directed packet traffic into the attribute extractor, words checked in order.
`timescale 1ns / 1ps
module tb_tuio_object_message_extractor_core;

	localparam int TAG_LEN      = tomx_pkg::TAG_LENGTH_DEF;
	localparam int POS_MAX      = (1 << tomx_pkg::POSITION_BITS_DEF) - 1;
	localparam int LIMIT_CYCLES = 500000;
	localparam int RANDOM_BYTES = 1900;
	localparam int FINAL_BYTES  = 200;
	localparam int HOLD_CYCLES  = 300;

	typedef struct packed {
		logic [tomx_pkg::WORD_W-1:0]  word;
		logic [tomx_pkg::INDEX_W-1:0] index;
		logic                         last;
	} attr_word_t;

	// Shadow copy of the extractor: registers, packet state and the words it owes.
	class attribute_tracker;
		logic [tomx_pkg::START_W-1:0]           first_start;
		logic [tomx_pkg::START_W-1:0]           last_start;
		logic [tomx_pkg::GAP_W-1:0]             gap_bytes;
		logic [tomx_pkg::TOTAL_W-1:0]           word_total;
		logic [tomx_pkg::POSITION_BITS_DEF-1:0] position;
		logic [tomx_pkg::BYTE_W-1:0]            tail_bytes [TAG_LEN];
		tomx_pkg::phase_t                       phase;
		logic [tomx_pkg::GAP_W-1:0]             skipped;
		logic [23:0]                            partial;
		logic [1:0]                             bytes_held;
		logic [tomx_pkg::INDEX_W-1:0]           words_sent;
		attr_word_t                             words_due [$];
		int                                     mismatches;
		int                                     words_checked;

		function new();
			first_start   = tomx_pkg::FIRST_START_RST;
			last_start    = tomx_pkg::LAST_START_RST;
			gap_bytes     = tomx_pkg::GAP_BYTES_RST;
			word_total    = tomx_pkg::WORD_TOTAL_RST;
			mismatches    = 0;
			words_checked = 0;
			clear_packet();
		endfunction

		function void clear_packet();
			position = '0;
			foreach (tail_bytes[i])
				tail_bytes[i] = '0;
			phase      = tomx_pkg::PH_SEARCH;
			skipped    = '0;
			partial    = '0;
			bytes_held = '0;
			words_sent = '0;
		endfunction

		function void load_reg(tomx_pkg::cfg_reg_t idx,
			logic [tomx_pkg::CFG_DATA_W-1:0] value);
			case (idx)
				tomx_pkg::REG_FIRST_START: first_start = value[tomx_pkg::START_W-1:0];
				tomx_pkg::REG_LAST_START:  last_start  = value[tomx_pkg::START_W-1:0];
				tomx_pkg::REG_GAP_BYTES:   gap_bytes   = value[tomx_pkg::GAP_W-1:0];
				tomx_pkg::REG_WORD_TOTAL:  word_total  = value[tomx_pkg::TOTAL_W-1:0];
				default: ;
			endcase
		endfunction

		function int clamped_total();
			return (word_total > tomx_pkg::MAX_WORDS_DEF) ? tomx_pkg::MAX_WORDS_DEF
				: int'(word_total);
		endfunction

		function void arm();
			skipped    = '0;
			bytes_held = '0;
			partial    = '0;
			words_sent = '0;
			if (clamped_total() == 0)
				phase = tomx_pkg::PH_DONE;
			else if (gap_bytes == 0)
				phase = tomx_pkg::PH_COLLECT;
			else
				phase = tomx_pkg::PH_SKIP;
		endfunction

		function void take_byte(logic [tomx_pkg::BYTE_W-1:0] b, logic eop);
			int         start;
			bit         hit;
			attr_word_t w;
			for (int i = 0; i < TAG_LEN - 1; i++)
				tail_bytes[i] = tail_bytes[i + 1];
			tail_bytes[TAG_LEN - 1] = b;
			case (phase)
				tomx_pkg::PH_SEARCH: begin
					if (int'(position) >= TAG_LEN - 1) begin
						// saturated position keeps giving the same start
						start = int'(position) - (TAG_LEN - 1);
						hit = (start >= int'(first_start)) && (start <= int'(last_start));
						for (int k = 0; k < TAG_LEN; k++)
							if (tail_bytes[k] != tomx_pkg::TAG_CHARS[k])
								hit = 1'b0;
						if (hit)
							arm();
					end
				end
				tomx_pkg::PH_SKIP: begin
					skipped = skipped + 1'b1;
					if (skipped >= gap_bytes || skipped == 0)
						phase = tomx_pkg::PH_COLLECT;
				end
				tomx_pkg::PH_COLLECT: begin
					if (bytes_held == 2'd3) begin
						w.word  = {partial, b};
						w.index = words_sent;
						w.last  = (int'(words_sent) + 1 >= clamped_total());
						words_due.push_back(w);
						partial    = '0;
						bytes_held = '0;
						words_sent = words_sent + 1'b1;
						if (w.last)
							phase = tomx_pkg::PH_DONE;
					end else begin
						partial    = {partial[15:0], b};
						bytes_held = bytes_held + 1'b1;
					end
				end
				default: ;
			endcase
			if (int'(position) < POS_MAX)
				position = position + 1'b1;
			if (eop)
				clear_packet();
		endfunction

		function void match_word(attr_word_t got);
			attr_word_t want;
			words_checked++;
			if (words_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: word %h index %0d last %0b arrived with none pending",
						got.word, got.index, got.last);
				return;
			end
			want = words_due.pop_front();
			if (got.word !== want.word || got.index !== want.index || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: expected word %h index %0d last %0b, got word %h index %0d last %0b",
						want.word, want.index, want.last, got.word, got.index, got.last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tomx_in_if  pkt_in ();
	tomx_out_if attr_out ();
	tomx_cfg_if cfg ();

	tuio_object_message_extractor_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pkt_in   (pkt_in),
		.attr_out (attr_out),
		.cfg      (cfg)
	);

	attribute_tracker            tracker = new();
	logic [tomx_pkg::BYTE_W-1:0] pkt_bytes [$];
	bit                          calm;
	bit                          hold_req;
	int                          cycle_count;
	int                          bytes_sent;
	int                          packets;
	int                          tweaks;
	int                          cfg_writes;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timed out after %0d cycles, %0d words pending", cycle_count,
				tracker.words_due.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// monitors: bytes and register writes feed the tracker, words get checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready)
				tracker.load_reg(tomx_pkg::cfg_reg_t'(cfg.index), cfg.data);
			if (pkt_in.valid && pkt_in.ready)
				tracker.take_byte(pkt_in.data_byte, pkt_in.end_of_packet);
			if (attr_out.valid && attr_out.ready)
				tracker.match_word(attr_word_t'({attr_out.attribute_word, attr_out.word_index,
					attr_out.last_word}));
		end
	end

	// receiver: random stall bursts, one long hold-off on demand
	initial begin
		int stall;
		stall = 0;
		attr_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				attr_out.ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
			end
			if (stall > 0) begin
				attr_out.ready <= 1'b0;
				stall--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(0, 7);
				attr_out.ready <= 1'b0;
			end else begin
				attr_out.ready <= 1'b1;
			end
		end
	end

	task automatic rest(input int n);
		pkt_in.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic push_byte(input logic [tomx_pkg::BYTE_W-1:0] b, input logic eop);
		if (!calm && $urandom_range(0, 5) == 0)
			rest($urandom_range(1, 8));
		pkt_in.valid         <= 1'b1;
		pkt_in.data_byte     <= b;
		pkt_in.end_of_packet <= eop;
		do @(posedge clk); while (!pkt_in.ready);
		bytes_sent++;
	endtask

	// wait until every owed word is out, then let the pipeline settle
	task automatic drain();
		pkt_in.valid <= 1'b0;
		do @(posedge clk); while (tracker.words_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input tomx_pkg::cfg_reg_t idx, input int value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value[tomx_pkg::CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg.ready);
		cfg_writes++;
	endtask

	task automatic end_writes();
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_all(input int fs, input int ls, input int gp, input int wt);
		write_reg(tomx_pkg::REG_FIRST_START, fs);
		write_reg(tomx_pkg::REG_LAST_START, ls);
		write_reg(tomx_pkg::REG_GAP_BYTES, gp);
		write_reg(tomx_pkg::REG_WORD_TOTAL, wt);
		end_writes();
	endtask

	task automatic send_packet(input int tweak_at);
		for (int i = 0; i < pkt_bytes.size(); i++) begin
			if (i == tweak_at) begin
				// change gap or word count while the packet is in flight
				drain();
				if ($urandom_range(0, 1))
					write_reg(tomx_pkg::REG_GAP_BYTES, $urandom_range(0, 6));
				else
					write_reg(tomx_pkg::REG_WORD_TOTAL, $urandom_range(0, 4));
				end_writes();
				tweaks++;
			end
			push_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
		end
		packets++;
	endtask

	task automatic add_random(input int n);
		repeat (n) pkt_bytes.push_back(8'($urandom));
	endtask

	task automatic add_tag();
		for (int k = 0; k < TAG_LEN; k++)
			pkt_bytes.push_back(tomx_pkg::TAG_CHARS[k]);
	endtask

	function automatic int pick_start();
		int lo;
		int hi;
		lo = tracker.first_start;
		hi = tracker.last_start;
		if (lo > 150 || hi < lo || $urandom_range(0, 5) == 0)
			return $urandom_range(0, 120);
		if (hi > lo + 60)
			hi = lo + 60;
		return $urandom_range(hi, lo);
	endfunction

	task automatic random_packet();
		int kind;
		int start;
		int tail;
		int tweak;
		int flip;
		kind  = $urandom_range(0, 19);
		tweak = -1;
		pkt_bytes.delete();
		if (kind < 3) begin
			add_random($urandom_range(1, 30));
		end else begin
			start = pick_start();
			add_random(start);
			add_tag();
			if (kind < 6) begin
				// broken tag: one bit flipped somewhere in it
				flip = pkt_bytes.size() - 1 - $urandom_range(0, TAG_LEN - 1);
				pkt_bytes[flip] = pkt_bytes[flip] ^ 8'(1 << $urandom_range(0, 7));
			end
			tail = tracker.gap_bytes + 4 * tracker.clamped_total() + $urandom_range(0, 5);
			if ($urandom_range(0, 3) == 0)
				tail = $urandom_range(0, tail);
			add_random(tail);
			if ($urandom_range(0, 11) == 0)
				tweak = start + TAG_LEN + $urandom_range(0, tail);
		end
		send_packet(tweak);
	endtask

	task automatic random_config();
		int fs;
		int ls;
		int gp;
		int wt;
		drain();
		fs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 60);
		case ($urandom_range(0, 9))
			0: ls = (fs > 0) ? $urandom_range(0, fs - 1) : 0;
			1: ls = 2047;
			default: ls = (fs + $urandom_range(0, 40) > 2047) ? 2047 : fs + $urandom_range(0, 40);
		endcase
		case ($urandom_range(0, 9))
			0: gp = 63;
			1: gp = $urandom_range(0, 63);
			2, 3, 4: gp = $urandom_range(5, 20);
			default: gp = $urandom_range(0, 4);
		endcase
		case ($urandom_range(0, 9))
			0: wt = 0;
			1: wt = $urandom_range(17, 31);
			2: wt = 16;
			default: wt = $urandom_range(1, 8);
		endcase
		set_all(fs, ls, gp, wt);
	endtask

	initial begin
		int mark;
		arst_n               <= 1'b0;
		pkt_in.valid         <= 1'b0;
		pkt_in.data_byte     <= '0;
		pkt_in.end_of_packet <= 1'b0;
		cfg.valid            <= 1'b0;
		cfg.index            <= tomx_pkg::REG_FIRST_START;
		cfg.data             <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tag at position zero, no gap, two words of all ones and all zeros
		set_all(0, 0, 0, 2);
		pkt_bytes.delete();
		add_tag();
		repeat (4) pkt_bytes.push_back(8'hFF);
		repeat (4) pkt_bytes.push_back(8'h00);
		send_packet(-1);
		// one-byte packet
		pkt_bytes.delete();
		pkt_bytes.push_back(8'hA5);
		send_packet(-1);

		// long receiver hold-off while a full packet streams in
		drain();
		set_all(0, 100, 0, 16);
		pkt_bytes.delete();
		add_random(5);
		add_tag();
		add_random(4 * tomx_pkg::MAX_WORDS_DEF + 3);
		hold_req = 1'b1;
		send_packet(-1);
		drain();

		// position counter runs into saturation before the tag shows up
		set_all(POS_MAX - (TAG_LEN - 1), POS_MAX, 3, 4);
		pkt_bytes.delete();
		add_random(POS_MAX + 12);
		add_tag();
		add_random(3 + 4 * 4 + 2);
		send_packet(-1);

		mark = bytes_sent;
		while (bytes_sent - mark < RANDOM_BYTES) begin
			if ($urandom_range(0, 7) == 0)
				random_config();
			random_packet();
		end

		// closing stretch with both sides running flat out
		drain();
		calm = 1'b1;
		set_all(10, 60, 2, 6);
		mark = bytes_sent;
		while (bytes_sent - mark < FINAL_BYTES)
			random_packet();
		drain();

		$display("Sent %0d bytes in %0d packets, checked %0d words, %0d register writes (%0d mid-packet)",
			bytes_sent, packets, tracker.words_checked, cfg_writes, tweaks);
		$display("Covered saturated position, empty and wide windows, zero and oversized word totals, stalls");
		if (tracker.mismatches == 0 && tracker.words_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### sim.f
rtl/tomx_pkg.sv
rtl/tomx_in_if.sv
rtl/tomx_out_if.sv
rtl/tomx_cfg_if.sv
rtl/tuio_object_message_extractor_core.sv
dv/tb_tuio_object_message_extractor_core.sv
